>>> design/dfme_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and arithmetic helpers for the decimating fir mu-law encoder
// no dependencies
package dfme_pkg;

   localparam int ROM_HALF = 32;
   localparam int SAMPLE_W = 24;
   localparam int IIR_ACC_W = 48;

   // Q2.16 fir coefficients for tap offsets 0..31 from the centre
   localparam logic signed [17:0] FIR_ROM [ROM_HALF] = '{
      18'sd18537, 18'sd16146, 18'sd10089, 18'sd3085, -18'sd2039, -18'sd3791, -18'sd2576,
      -18'sd138, 18'sd1658, 18'sd1878, 18'sd816, -18'sd504, -18'sd1155, -18'sd880,
      -18'sd95, 18'sd553, 18'sd669, 18'sd314, -18'sd152, -18'sd389, -18'sd304,
      -18'sd46, 18'sd164, 18'sd202, 18'sd97, -18'sd35, -18'sd101, -18'sd81,
      -18'sd16, 18'sd40, 18'sd57, 18'sd34
   };

   // Q.20 iir coefficients; feedback terms stored negated
   localparam logic signed [21:0] DC_ALPHA = 22'sd1043092;
   localparam logic signed [21:0] SH_B0 = 22'sd1371841;
   localparam logic signed [21:0] SH_B1 = -22'sd1611137;
   localparam logic signed [21:0] SH_B2 = 22'sd585577;
   localparam logic signed [21:0] SH_NA1 = 22'sd1090005;
   localparam logic signed [21:0] SH_NA2 = -22'sd387365;

   localparam logic signed [23:0] ONE_Q20 = 24'sd1048576;
   localparam logic [15:0] MU_CLIP = 16'd32635;
   localparam logic [15:0] MU_BIAS = 16'd132;

   typedef struct packed {
      logic clear;
      logic push;
      logic start;
   } fir_ctrl_type;

   // round half up, floor shift by 20, saturate to 24 bits
   function automatic logic signed [23:0] round_q20(input logic signed [47:0] acc);
      logic signed [47:0] s;
      logic signed [27:0] q;
      s = acc + 48'sd524288;
      q = 28'(s >>> 20);
      if (q > 28'sd8388607) return 24'sh7fffff;
      if (q < -28'sd8388608) return 24'sh800000;
      return 24'(q);
   endfunction

   function automatic int coef_at(input int t, input int half, input int frac);
      int k;
      int c;
      k = t - half;
      if (k < 0) k = -k;
      if (k >= ROM_HALF) return 0;
      c = int'(FIR_ROM[k]);
      if (frac >= 16) return c <<< (frac - 16);
      return (c + (1 <<< (15 - frac))) >>> (16 - frac);
   endfunction

   function automatic logic [7:0] mulaw_encode(input logic signed [15:0] pcm);
      logic sgn;
      logic [15:0] mag;
      logic [2:0] ex;
      logic [3:0] mant;
      logic found;
      sgn = pcm[15];
      mag = sgn ? 16'(-pcm) : 16'(pcm);
      if (mag > MU_CLIP) mag = MU_CLIP;
      mag = mag + MU_BIAS;
      ex = 3'd0;
      found = 1'b0;
      for (int i = 7; i >= 1; i--) begin
         if (!found && mag[i + 7]) begin
            ex = 3'(i);
            found = 1'b1;
         end
      end
      mant = 4'(mag >> ({1'b0, ex} + 4'd3));
      return ~{sgn, ex, mant};
   endfunction

endpackage

>>> design/dfme_iir.sv
`timescale 1ns / 1ps
// dc blocker and optional high-shelf biquad on one shared multiply-accumulate
// depends on dfme_pkg
module dfme_iir import dfme_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       restart,
   input  logic                       shelf_en,
   input  logic signed [SAMPLE_W-1:0] x,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] y
);

   typedef enum logic [2:0] {ST_IDLE, ST_DC, ST_DC_RND, ST_SH, ST_SH_RND} state_type;

   state_type state_ff;
   logic signed [SAMPLE_W-1:0] x_ff, dc_in_ff, dc_out_ff, ydc_ff, y_ff;
   logic signed [SAMPLE_W-1:0] in0_ff, in1_ff, out0_ff, out1_ff;
   logic signed [IIR_ACC_W-1:0] acc_ff;
   logic [2:0] step_ff;
   logic done_ff;

   logic signed [21:0] coef;
   logic signed [SAMPLE_W-1:0] opnd;
   logic signed [IIR_ACC_W-1:0] prod, rnd_acc, dc_diff;
   logic signed [SAMPLE_W-1:0] rnd;

   always_comb begin
      coef = DC_ALPHA;
      opnd = dc_out_ff;
      if (state_ff == ST_SH) begin
         case (step_ff)
            3'd0: begin coef = SH_B0; opnd = ydc_ff; end
            3'd1: begin coef = SH_B1; opnd = in0_ff; end
            3'd2: begin coef = SH_B2; opnd = in1_ff; end
            3'd3: begin coef = SH_NA1; opnd = out0_ff; end
            default: begin coef = SH_NA2; opnd = out1_ff; end
         endcase
      end
      prod = coef * opnd;
      dc_diff = (IIR_ACC_W'(x_ff) - IIR_ACC_W'(dc_in_ff)) <<< 20;
      rnd_acc = acc_ff;
      rnd = round_q20(rnd_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
         dc_in_ff <= '0;
         dc_out_ff <= '0;
         in0_ff <= '0;
         in1_ff <= '0;
         out0_ff <= '0;
         out1_ff <= '0;
         step_ff <= '0;
      end else begin
         done_ff <= (state_ff == ST_DC_RND && !shelf_en) || state_ff == ST_SH_RND;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (restart) begin
                     dc_in_ff <= '0;
                     dc_out_ff <= '0;
                     in0_ff <= '0;
                     in1_ff <= '0;
                     out0_ff <= '0;
                     out1_ff <= '0;
                  end
                  state_ff <= ST_DC;
               end
            end
            ST_DC: state_ff <= ST_DC_RND;
            ST_DC_RND: begin
               dc_in_ff <= x_ff;
               dc_out_ff <= rnd;
               step_ff <= '0;
               if (shelf_en) begin
                  state_ff <= ST_SH;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SH: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd4) state_ff <= ST_SH_RND;
            end
            ST_SH_RND: begin
               in1_ff <= in0_ff;
               in0_ff <= ydc_ff;
               out1_ff <= out0_ff;
               out0_ff <= rnd;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) x_ff <= x;
      if (state_ff == ST_DC) acc_ff <= dc_diff + prod;
      if (state_ff == ST_DC_RND) begin
         ydc_ff <= rnd;
         y_ff <= rnd;
         acc_ff <= '0;
      end
      if (state_ff == ST_SH) acc_ff <= acc_ff + prod;
      if (state_ff == ST_SH_RND) begin
         if (rnd > ONE_Q20) y_ff <= ONE_Q20;
         else if (rnd < -ONE_Q20) y_ff <= -ONE_Q20;
         else y_ff <= rnd;
      end
   end

   assign done = done_ff;
   assign y = y_ff;

endmodule

>>> design/dfme_fir.sv
`timescale 1ns / 1ps
// delay line memory with fir multiply-accumulate and output scaling
// depends on dfme_pkg
module dfme_fir import dfme_pkg::*; #(
   parameter int TAP_COUNT = 63,
   parameter int COEF_WIDTH = 18
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fir_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] fill,
   input  logic signed [SAMPLE_W-1:0] y,
   output logic                       done,
   output logic signed [15:0]         pcm
);

   localparam int AW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam int HALF = TAP_COUNT / 2;
   localparam int ACC_W = SAMPLE_W + COEF_WIDTH + 8;
   localparam int FR = 20 + COEF_WIDTH - 2;
   localparam int LSH = (FR < 36) ? 36 - FR : 0;
   localparam int RSH = (FR > 36) ? FR - 36 : 0;
   localparam int MW = ACC_W + LSH;
   localparam logic [AW-1:0] LAST = AW'(TAP_COUNT - 1);

   logic signed [SAMPLE_W-1:0] mem [TAP_COUNT];
   logic [TAP_COUNT-1:0] valid_ff;
   logic signed [SAMPLE_W-1:0] fill_ff, rd_ff;
   logic [AW-1:0] wp_ff, wp_in, addr_ff, tap_ff;
   logic run_ff, dv_ff, dl_ff, rv_ff, p1_ff, p2_ff, done_ff, neg_ff;
   logic signed [COEF_WIDTH-1:0] coef_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [36:0] clip_ff;
   logic signed [15:0] pcm_ff;

   logic signed [SAMPLE_W-1:0] opnd;
   logic signed [SAMPLE_W+COEF_WIDTH-1:0] prod;
   logic [ACC_W-1:0] mag;
   logic [MW-1:0] wide;
   logic [51:0] scaled;
   logic [15:0] pcm_mag;

   always_comb begin
      wp_in = wp_ff;
      if (ctrl.push) wp_in = (wp_ff == LAST) ? '0 : wp_ff + AW'(1);
      opnd = rv_ff ? rd_ff : fill_ff;
      prod = opnd * coef_ff;
      mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      wide = (MW'(mag) << LSH) >> RSH;
      scaled = {clip_ff, 15'b0} - {15'b0, clip_ff};
      pcm_mag = scaled[51:36];
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) mem[wp_in] <= y;
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff <= '0;
         wp_ff <= '0;
         run_ff <= 1'b0;
         dv_ff <= 1'b0;
         dl_ff <= 1'b0;
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (ctrl.clear) begin
            valid_ff <= '0;
            fill_ff <= fill;
         end else if (ctrl.push) begin
            valid_ff[wp_in] <= 1'b1;
         end
         wp_ff <= wp_in;
         if (ctrl.start) run_ff <= 1'b1;
         else if (run_ff && tap_ff == LAST) run_ff <= 1'b0;
         dv_ff <= run_ff;
         dl_ff <= run_ff && tap_ff == LAST;
         p1_ff <= dv_ff && dl_ff;
         p2_ff <= p1_ff;
         done_ff <= p2_ff;
      end
   end

   // address walk runs from the newest sample backwards through the ring
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         addr_ff <= wp_in;
         tap_ff <= '0;
      end else if (run_ff) begin
         addr_ff <= (addr_ff == '0) ? LAST : addr_ff - AW'(1);
         tap_ff <= tap_ff + AW'(1);
      end
      rv_ff <= valid_ff[addr_ff];
      coef_ff <= COEF_WIDTH'(coef_at(int'(tap_ff), HALF, COEF_WIDTH - 2));
      if (ctrl.start) acc_ff <= '0;
      else if (dv_ff) acc_ff <= acc_ff + ACC_W'(prod);
      if (p1_ff) begin
         neg_ff <= acc_ff[ACC_W-1];
         clip_ff <= (wide > (MW'(1) << 36)) ? 37'h1000000000 : wide[36:0];
      end
      if (p2_ff) pcm_ff <= neg_ff ? -$signed(pcm_mag) : $signed(pcm_mag);
   end

   assign done = done_ff;
   assign pcm = pcm_ff;

endmodule

>>> design/decimating_fir_mulaw_encoder.sv
`timescale 1ns / 1ps
// top level: decimating fir with dc blocker, presence shelf and mu-law output
// depends on dfme_pkg, dfme_iir, dfme_fir
//
// usage: one Q1.15 sample per req transaction (req_valid/req_stall), with
// req_restart to clear the filter state and prefill the delay line with it.
// results leave on rsp_valid/rsp_stall as a pcm value and its mu-law byte.
// csr_valid/csr_ready writes presence_enable; csr_ready is always high.
// an item runs the iir through one shared multiplier: the dc blocker step and its
// rounding, then with the shelf on the biquad products and their rounding. on a
// result item the fir then walks the TAP_COUNT-entry delay memory one read per
// cycle, and the sum is scaled, clipped and registered as the pcm result.
// the first TAP_COUNT/2 samples after reset or restart give no result.
// reset clears all filter state, the delay line reads as zero and the shelf is
// off. while rsp_stall holds a result, the next result waits and req_stall
// stays high; the input side is free again as soon as a result is registered.
module decimating_fir_mulaw_encoder import dfme_pkg::*; #(
   parameter int TAP_COUNT = 63,
   parameter int DECIMATION = 3,
   parameter int COEF_WIDTH = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_in,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_ulaw_code,
   output logic signed [15:0] rsp_pcm_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_presence_enable
);

   localparam int HALF = TAP_COUNT / 2;
   localparam int WW = $clog2(HALF + 1);
   localparam int PW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_IIR, ST_FIR, ST_EMIT} state_type;

   state_type state_ff;
   logic presence_ff, rsp_valid_ff;
   logic [WW-1:0] warm_ff;
   logic [PW-1:0] phase_ff;
   logic [7:0] ulaw_ff;
   logic signed [15:0] pcm_out_ff, pcm_hold_ff;

   logic accept, iir_done, fir_done, out_free;
   logic signed [SAMPLE_W-1:0] x, iir_y;
   logic signed [15:0] fir_pcm;
   fir_ctrl_type fir_ctrl;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign x = {{3{req_sample_in[15]}}, req_sample_in, 5'b0};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fir_ctrl.clear = accept && req_restart;
      fir_ctrl.push = (state_ff == ST_IIR) && iir_done;
      fir_ctrl.start = fir_ctrl.push && warm_ff >= WW'(HALF) && phase_ff == '0;
   end

   dfme_iir u_iir (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .restart(req_restart),
      .shelf_en(presence_ff),
      .x(x),
      .done(iir_done),
      .y(iir_y)
   );

   dfme_fir #(.TAP_COUNT(TAP_COUNT), .COEF_WIDTH(COEF_WIDTH)) u_fir (
      .clock(clock),
      .reset(reset),
      .ctrl(fir_ctrl),
      .fill(x),
      .y(iir_y),
      .done(fir_done),
      .pcm(fir_pcm)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         presence_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         warm_ff <= '0;
         phase_ff <= '0;
      end else begin
         if (csr_valid) presence_ff <= csr_presence_enable;
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_restart) begin
                     warm_ff <= '0;
                     phase_ff <= '0;
                  end
                  state_ff <= ST_IIR;
               end
            end
            ST_IIR: begin
               if (iir_done) begin
                  if (warm_ff < WW'(HALF)) begin
                     warm_ff <= warm_ff + WW'(1);
                     state_ff <= ST_IDLE;
                  end else if (phase_ff != '0) begin
                     phase_ff <= (32'(phase_ff) + 1 >= DECIMATION) ? '0 : phase_ff + PW'(1);
                     state_ff <= ST_IDLE;
                  end else begin
                     phase_ff <= (DECIMATION > 1) ? PW'(1) : '0;
                     state_ff <= ST_FIR;
                  end
               end
            end
            ST_FIR: if (fir_done) state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIR && fir_done) pcm_hold_ff <= fir_pcm;
      if (state_ff == ST_EMIT && out_free) begin
         pcm_out_ff <= pcm_hold_ff;
         ulaw_ff <= mulaw_encode(pcm_hold_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ulaw_code = ulaw_ff;
   assign rsp_pcm_value = pcm_out_ff;

endmodule
